FILE: hw/rtl/gn2_pkg.sv
// shared constants and types for the 2d gradient noise unit
package gn2_pkg;

  localparam int unsigned MAX_GRID_SIDE = 64;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned TIDX_W  = 12;
  localparam int unsigned NOISE_W = 20;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic signed [NOISE_W-1:0] NOISE_MIN = -20'sd524288;
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 20'sd524287;

  typedef logic signed [NOISE_W-1:0] noise_t;

endpackage

FILE: hw/rtl/gn2_if.sv
// valid/ready channel interfaces for input items and noise results
interface gn2_in_if import gn2_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TIDX_W-1:0]  table_index;
  logic              table_bit;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;

  modport source (output valid, mode, table_index, table_bit, x_coord, y_coord,
                  input ready);
  modport sink   (input valid, mode, table_index, table_bit, x_coord, y_coord,
                  output ready);
endinterface

interface gn2_out_if import gn2_pkg::*; ();
  logic   valid;
  logic   ready;
  noise_t noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

FILE: hw/rtl/gn2_rem.sv
// pipelined restoring remainder, one dividend bit per stage
module gn2_rem #(
  parameter int unsigned NB = 16,
  parameter int unsigned DW = 7
) (
  input  logic          clk_i,
  input  logic [NB-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [DW-1:0] rem_o
);

  logic [DW-1:0] rem_q  [NB];
  logic [NB-1:0] bits_q [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [DW-1:0] prev_rem;
    logic [NB-1:0] prev_bits;
    logic [DW:0]   trial;
    logic [DW-1:0] rem_d;

    always_comb begin
      prev_rem  = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k-1];
      prev_bits = (k == 0) ? dividend_i : bits_q[(k == 0) ? 0 : k-1];
      trial     = {prev_rem, prev_bits[NB-1]};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      bits_q[k] <= prev_bits << 1;
    end
  end

  assign rem_o = rem_q[NB-1];

endmodule

FILE: hw/rtl/gn2_fade.sv
// four-stage quintic fade 6t^5-15t^4+10t^3 with truncating steps
module gn2_fade #(
  parameter int unsigned F = 16
) (
  input  logic         clk_i,
  input  logic [F-1:0] t_i,
  output logic [F:0]   fade_o
);

  localparam int unsigned CW = F + 4;
  localparam int unsigned PW = CW + F;
  localparam logic [CW-1:0] S15 = CW'(15) << F;
  localparam logic [CW-1:0] S10 = CW'(10) << F;

  logic [PW-1:0] p1_q, p2_q, p3_q, p4_q;
  logic [F-1:0]  t1_q, t2_q, t3_q;
  logic [CW-1:0] a, c;

  always_comb begin
    a = S15 - CW'(6 * CW'(t_i));
    c = S10 - p1_q[PW-1:F];
  end

  always_ff @(posedge clk_i) begin
    p1_q <= PW'(a * t_i);
    t1_q <= t_i;
    p2_q <= PW'(c * t1_q);
    t2_q <= t1_q;
    p3_q <= PW'(p2_q[PW-1:F] * t2_q);
    t3_q <= t2_q;
    p4_q <= PW'(p3_q[PW-1:F] * t3_q);
  end

  assign fade_o = p4_q[2*F:F];

endmodule

FILE: hw/rtl/gn2_sign_mem.sv
// gradient sign store: two identical copies, each with two read ports
module gn2_sign_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wbit_i,
  input  logic [AW-1:0] raddr_i [4],
  output logic [3:0]    rbit_o
);

  // copy a serves the lower row of corners, copy b the upper row
  logic mem_a [DEPTH];
  logic mem_b [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_a[waddr_i] <= wbit_i;
      mem_b[waddr_i] <= wbit_i;
    end
    rbit_o[0] <= mem_a[raddr_i[0]];
    rbit_o[1] <= mem_a[raddr_i[1]];
    rbit_o[2] <= mem_b[raddr_i[2]];
    rbit_o[3] <= mem_b[raddr_i[3]];
  end

endmodule

FILE: hw/rtl/gn2_out_fifo.sv
// result queue that decouples the fixed-latency pipeline from the sink
module gn2_out_fifo import gn2_pkg::*; #(
  parameter int unsigned AW = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  noise_t     push_data_i,
  gn2_out_if.source  out_chan
);

  localparam int unsigned FD = 1 << AW;

  noise_t        mem_q [FD];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          pop;

  assign out_chan.valid       = (cnt_q != '0);
  assign out_chan.noise_value = mem_q[rptr_q];
  assign pop                  = out_chan.valid & out_chan.ready;

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + (AW+1)'(push_i) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/gradient_noise_2d_unit.sv
// Two-dimensional gradient noise unit. Takes one transaction per clock and
// never stalls internally: load transactions write a sign bit and give no
// result, evaluate transactions give one signed Q3.16 result each, which
// passes through the bit-per-stage modulo pipeline that wraps the cell
// indices. The sign table sits in two mirrored memories with registered
// reads; loads write at the same pipeline stage where evaluates read, so no
// forwarding is needed. The input is throttled only when the result queue
// could overflow.
module gradient_noise_2d_unit import gn2_pkg::*; #(
  parameter int unsigned COORD_FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  gn2_in_if.sink               in_chan,
  gn2_out_if.source            out_chan
);

  localparam int unsigned F     = COORD_FRACTION_BITS;
  localparam int unsigned SIDE  = MAX_GRID_SIDE;
  localparam int unsigned IXW   = COORD_W - F;
  localparam int unsigned WW    = $clog2(SIDE + 1);
  localparam int unsigned DEPTH = SIDE * SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned M     = IXW;
  localparam int unsigned FD_W  = $clog2(M + 7);
  localparam int unsigned FD    = 1 << FD_W;
  localparam int unsigned FDL   = M - 3;
  localparam int unsigned VW    = F + 3;
  localparam int unsigned PW    = 2 * F + 5;
  localparam int unsigned RW    = F + 4;
  localparam int unsigned MW    = 2 * F + 6;
  localparam int unsigned QW    = F + 4 + 16;
  localparam int unsigned RST_SIDE = (SIDE < 64) ? SIDE : 64;
  localparam logic signed [VW-1:0] S_V  = VW'(1) << F;
  localparam logic [F:0]           S_U  = (F+1)'(1) << F;

  // configuration, kept as effective sizes
  logic [WW-1:0] grid_w_q, grid_h_q, cfg_eff;
  logic [9:0]    cfg_ext;

  always_comb begin
    cfg_ext = 10'(cfg_data_i);
    if (cfg_ext == '0) begin
      cfg_eff = WW'(1);
    end else if (cfg_ext > 10'(SIDE)) begin
      cfg_eff = WW'(SIDE);
    end else begin
      cfg_eff = WW'(cfg_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= WW'(RST_SIDE);
      grid_h_q <= WW'(RST_SIDE);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH:  grid_w_q <= cfg_eff;
        CFG_GRID_HEIGHT: grid_h_q <= cfg_eff;
        default: ;
      endcase
    end
  end

  // admission: count evaluates in flight or queued
  logic [FD_W:0] pend_q, pend_d;
  logic          acc, acc_eval, pop;

  assign in_chan.ready = (pend_q < (FD_W+1)'(FD));
  assign acc      = in_chan.valid & in_chan.ready;
  assign acc_eval = acc & (in_chan.mode == MODE_EVAL);
  assign pop      = out_chan.valid & out_chan.ready;
  assign pend_d   = pend_q + (FD_W+1)'(acc_eval) - (FD_W+1)'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // stage 0 input register
  logic              s0_valid_q, s0_mode_q, s0_bit_q;
  logic [TIDX_W-1:0] s0_idx_q;
  logic [IXW-1:0]    s0_ix_q, s0_iy_q;
  logic [F-1:0]      s0_tx_q, s0_ty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_mode_q <= in_chan.mode;
    s0_bit_q  <= in_chan.table_bit;
    s0_idx_q  <= in_chan.table_index;
    s0_ix_q   <= in_chan.x_coord[COORD_W-1:F];
    s0_iy_q   <= in_chan.y_coord[COORD_W-1:F];
    s0_tx_q   <= in_chan.x_coord[F-1:0];
    s0_ty_q   <= in_chan.y_coord[F-1:0];
  end

  // cell index wrap and fade
  logic [WW-1:0] c0, r0;
  logic [F:0]    fade_x, fade_y;

  gn2_rem #(.NB(IXW), .DW(WW)) u_rem_x (
    .clk_i, .dividend_i(s0_ix_q), .divisor_i(grid_w_q), .rem_o(c0)
  );
  gn2_rem #(.NB(IXW), .DW(WW)) u_rem_y (
    .clk_i, .dividend_i(s0_iy_q), .divisor_i(grid_h_q), .rem_o(r0)
  );
  gn2_fade #(.F(F)) u_fade_x (.clk_i, .t_i(s0_tx_q), .fade_o(fade_x));
  gn2_fade #(.F(F)) u_fade_y (.clk_i, .t_i(s0_ty_q), .fade_o(fade_y));

  // delay lines up to the table stage
  logic              dl_valid_q [M];
  logic              dl_mode_q  [M];
  logic              dl_bit_q   [M];
  logic [TIDX_W-1:0] dl_idx_q   [M];
  logic [F-1:0]      dl_tx_q    [M];
  logic [F-1:0]      dl_ty_q    [M];
  logic [F:0]        fd_x_q     [FDL];
  logic [F:0]        fd_y_q     [FDL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < M; k++) dl_valid_q[k] <= 1'b0;
    end else begin
      dl_valid_q[0] <= s0_valid_q;
      for (int k = 1; k < M; k++) dl_valid_q[k] <= dl_valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dl_mode_q[0] <= s0_mode_q;
    dl_bit_q[0]  <= s0_bit_q;
    dl_idx_q[0]  <= s0_idx_q;
    dl_tx_q[0]   <= s0_tx_q;
    dl_ty_q[0]   <= s0_ty_q;
    for (int k = 1; k < M; k++) begin
      dl_mode_q[k] <= dl_mode_q[k-1];
      dl_bit_q[k]  <= dl_bit_q[k-1];
      dl_idx_q[k]  <= dl_idx_q[k-1];
      dl_tx_q[k]   <= dl_tx_q[k-1];
      dl_ty_q[k]   <= dl_ty_q[k-1];
    end
    fd_x_q[0] <= fade_x;
    fd_y_q[0] <= fade_y;
    for (int k = 1; k < FDL; k++) begin
      fd_x_q[k] <= fd_x_q[k-1];
      fd_y_q[k] <= fd_y_q[k-1];
    end
  end

  // table stage: loads write here, evaluates read here
  logic          m_load, m_eval, m_we;
  logic [WW-1:0] c1, r1;
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic [3:0]    gbit;

  always_comb begin
    m_load = dl_valid_q[M-1] & (dl_mode_q[M-1] == MODE_LOAD);
    m_eval = dl_valid_q[M-1] & (dl_mode_q[M-1] == MODE_EVAL);
    c1 = (c0 + 1'b1 == grid_w_q) ? '0 : c0 + 1'b1;
    r1 = (r0 + 1'b1 == grid_h_q) ? '0 : r0 + 1'b1;
    raddr[0] = AW'(c0 * SIDE + r0);
    raddr[1] = AW'(c1 * SIDE + r0);
    raddr[2] = AW'(c0 * SIDE + r1);
    raddr[3] = AW'(c1 * SIDE + r1);
    waddr = AW'(dl_idx_q[M-1]);
    m_we  = m_load & (32'(dl_idx_q[M-1]) < 32'(DEPTH));
  end

  gn2_sign_mem #(.DEPTH(DEPTH), .AW(AW)) u_sign_mem (
    .clk_i, .we_i(m_we), .waddr_i(waddr), .wbit_i(dl_bit_q[M-1]),
    .raddr_i(raddr), .rbit_o(gbit)
  );

  // blend stages
  logic                   e1_valid_q, e2_valid_q, e3_valid_q, e4_valid_q, e5_valid_q;
  logic [F-1:0]           e1_tx_q, e1_ty_q;
  logic signed [VW-1:0]   v0, v1, v3, sv0, sv1a, sv1b, sv3;
  logic signed [F+1:0]    sfx, fxs;
  logic signed [PW-1:0]   p0_q, p1_q, p2_q, p3_q;
  logic [F:0]             fy2_q, fy3_q;
  logic signed [PW:0]     suma, sumb;
  logic signed [RW-1:0]   ra_q, rb_q;
  logic signed [MW-1:0]   m0_q, m1_q;
  logic signed [MW:0]     sumr;
  logic signed [RW-1:0]   r;
  logic signed [QW-1:0]   q;
  noise_t                 q_sat, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
      e2_valid_q <= 1'b0;
      e3_valid_q <= 1'b0;
      e4_valid_q <= 1'b0;
      e5_valid_q <= 1'b0;
    end else begin
      e1_valid_q <= m_eval;
      e2_valid_q <= e1_valid_q;
      e3_valid_q <= e2_valid_q;
      e4_valid_q <= e3_valid_q;
      e5_valid_q <= e4_valid_q;
    end
  end

  always_comb begin
    v0   = VW'(e1_tx_q) + VW'(e1_ty_q);
    v1   = v0 - S_V;
    v3   = v1 - S_V;
    sv0  = gbit[0] ? v0 : -v0;
    sv1a = gbit[1] ? v1 : -v1;
    sv1b = gbit[2] ? v1 : -v1;
    sv3  = gbit[3] ? v3 : -v3;
    sfx  = $signed({1'b0, S_U - fd_x_q[FDL-1]});
    fxs  = $signed({1'b0, fd_x_q[FDL-1]});
    suma = (PW+1)'(p0_q) + (PW+1)'(p1_q);
    sumb = (PW+1)'(p2_q) + (PW+1)'(p3_q);
    sumr = (MW+1)'(m0_q) + (MW+1)'(m1_q);
    r    = RW'(sumr >>> F);
    // floor to Q.16 for any fraction width
    q    = (QW'(r) <<< 16) >>> F;
    if (q < QW'(NOISE_MIN)) begin
      q_sat = NOISE_MIN;
    end else if (q > QW'(NOISE_MAX)) begin
      q_sat = NOISE_MAX;
    end else begin
      q_sat = NOISE_W'(q);
    end
  end

  always_ff @(posedge clk_i) begin
    e1_tx_q <= dl_tx_q[M-1];
    e1_ty_q <= dl_ty_q[M-1];
    p0_q  <= PW'(sfx * sv0);
    p1_q  <= PW'(fxs * sv1a);
    p2_q  <= PW'(sfx * sv1b);
    p3_q  <= PW'(fxs * sv3);
    fy2_q <= fd_y_q[FDL-1];
    ra_q  <= RW'(suma >>> F);
    rb_q  <= RW'(sumb >>> F);
    fy3_q <= fy2_q;
    m0_q  <= MW'($signed({1'b0, S_U - fy3_q}) * ra_q);
    m1_q  <= MW'($signed({1'b0, fy3_q}) * rb_q);
    res_q <= q_sat;
  end

  gn2_out_fifo #(.AW(FD_W)) u_out_fifo (
    .clk_i, .rst_ni, .push_i(e5_valid_q), .push_data_i(res_q), .out_chan
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= (FD_W+1)'(FD))
    else $error("more evaluates in flight than the result queue holds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid |-> pend_q != '0)
    else $error("result offered with no evaluate outstanding");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_chan.mode == MODE_LOAD && !pop) |=> $stable(pend_q))
    else $error("load transaction changed the outstanding count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_we |-> !m_eval)
    else $error("table write and read in the same stage");

endmodule

FILE: sim/gn2_noise_checker.sv
// checker for the 2d gradient noise unit: predicts noise values and compares results
module gn2_noise_checker import gn2_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             in_mode_i,
  input  logic [TIDX_W-1:0] in_index_i,
  input  logic             in_bit_i,
  input  logic [COORD_W-1:0] in_x_i,
  input  logic [COORD_W-1:0] in_y_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  noise_t           out_noise_i,
  output int               errors_o,
  output int               pending_o
);

  localparam longint FRAC = 16;
  localparam longint ONE = 64'sd1 << FRAC;

  logic       sign_tbl [4096];
  logic [6:0] width_q, height_q;
  noise_t     noise_q[$];

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint fade(longint t);
    longint c, d;
    c = 10 * ONE - (((15 * ONE - 6 * t) * t) >>> FRAC);
    d = (c * t) >>> FRAC;
    d = (d * t) >>> FRAC;
    d = (d * t) >>> FRAC;
    return d;
  endfunction

  function automatic longint eff_side(logic [6:0] r);
    if (r == 0) return 1;
    if (r > 64) return 64;
    return r;
  endfunction

  function automatic longint corner(longint col, longint row);
    return sign_tbl[col * 64 + row] ? 1 : -1;
  endfunction

  function automatic noise_t noise_of(logic [31:0] x, logic [31:0] y);
    longint w, h, ix, iy, c0, c1, r0, r1, tx, ty, fx, fy, ra, rb, r;
    w = eff_side(width_q);
    h = eff_side(height_q);
    ix = x >> FRAC;
    iy = y >> FRAC;
    c0 = ix % w; c1 = (ix + 1) % w;
    r0 = iy % h; r1 = (iy + 1) % h;
    tx = x[15:0];
    ty = y[15:0];
    fx = fade(tx);
    fy = fade(ty);
    ra = floor_shr((ONE - fx) * corner(c0, r0) * (tx + ty)
                   + fx * corner(c1, r0) * (tx + ty - ONE), FRAC);
    rb = floor_shr((ONE - fx) * corner(c0, r1) * (tx + ty - ONE)
                   + fx * corner(c1, r1) * (tx + ty - 2 * ONE), FRAC);
    r = floor_shr((ONE - fy) * ra + fy * rb, FRAC);
    if (r < -524288) r = -524288;
    if (r > 524287) r = 524287;
    return noise_t'(r);
  endfunction

  task automatic report(string what, noise_t got, noise_t want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors_o++;
  endtask

  assign pending_o = noise_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 7'd64;
      height_q <= 7'd64;
      errors_o = 0;
      noise_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_GRID_WIDTH) width_q <= cfg_data_i;
        else if (cfg_idx_i == CFG_GRID_HEIGHT) height_q <= cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (noise_q.size() == 0) report("unexpected result", out_noise_i, 0);
        else begin
          noise_t want;
          want = noise_q.pop_front();
          if (out_noise_i !== want) report("noise_value", out_noise_i, want);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_mode_i == MODE_LOAD) sign_tbl[in_index_i] = in_bit_i;
        else noise_q.push_back(noise_of(in_x_i, in_y_i));
      end
    end
  end

endmodule

FILE: sim/tb_gradient_noise_2d_unit.sv
// testbench top for the 2d gradient noise unit: stimulus and verdict
module tb_gradient_noise_2d_unit import gn2_pkg::*; ();

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  int errors, pending, send_idle, recv_idle, stall_cycles;
  logic done;

  gn2_in_if  in_chan ();
  gn2_out_if out_chan ();

  gradient_noise_2d_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  gn2_noise_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_chan.valid), .in_ready_i(in_chan.ready),
    .in_mode_i(in_chan.mode), .in_index_i(in_chan.table_index),
    .in_bit_i(in_chan.table_bit), .in_x_i(in_chan.x_coord),
    .in_y_i(in_chan.y_coord), .out_valid_i(out_chan.valid),
    .out_ready_i(out_chan.ready), .out_noise_i(out_chan.noise_value),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || !rst_ni)
      stall_cycles <= 0;
    else if (!done) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 4000) begin
        $display("gradient_noise_2d_unit verification failed");
        $finish;
      end
    end
  end

  task automatic send(logic m, logic [11:0] idx, logic b, logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid       <= 1'b1;
    in_chan.mode        <= m;
    in_chan.table_index <= idx;
    in_chan.table_bit   <= b;
    in_chan.x_coord     <= x;
    in_chan.y_coord     <= y;
    do @(posedge clk_i); while (!in_chan.ready);
  endtask

  task automatic load_bit(logic [5:0] col, logic [5:0] row, logic b);
    send(MODE_LOAD, {col, row}, b, $urandom, $urandom);
  endtask

  task automatic eval_at(logic [31:0] x, logic [31:0] y);
    send(MODE_EVAL, 12'($urandom), 1'($urandom), x, y);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [6:0] w, logic [6:0] h);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_GRID_WIDTH; cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= CFG_GRID_HEIGHT; cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // fill the two low columns and the two low and two high rows: every corner
  // that a directed evaluate in this test can reach lies there
  task automatic fill_table(bit all_ones, bit all_rand);
    for (int c = 0; c < 64; c++)
      for (int r = 0; r < 64; r++)
        if (c < 2 || r < 2 || r >= 62)
          load_bit(6'(c), 6'(r), all_rand ? 1'($urandom) : all_ones);
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) load_bit(6'($urandom), 6'($urandom), 1'($urandom));
      else if (sel == 1) eval_at($urandom, $urandom);
      else if (sel == 2) eval_at({16'($urandom_range(3)), 16'($urandom)},
                                 {16'hffff - 16'($urandom_range(3)), 16'($urandom)});
      else eval_at({16'($urandom_range(200)), 16'($urandom)},
                   {16'($urandom_range(200)), 16'($urandom)});
    end
  endtask

  initial begin
    logic [6:0] sizes [6] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd37};
    done = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_chan.valid = 1'b0; in_chan.mode = MODE_LOAD; in_chan.table_index = '0;
    in_chan.table_bit = 1'b0; in_chan.x_coord = '0; in_chan.y_coord = '0;
    send_idle = 0; recv_idle = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all +1 signs, then one corner flipped to -1, with extreme coordinates
    fill_table(1'b1, 1'b0);
    eval_at(32'h0, 32'h0);
    eval_at(32'hffff_ffff, 32'hffff_ffff);
    eval_at(32'h0000_ffff, 32'h0000_8000);
    eval_at(32'h0001_8000, 32'hffff_0000);
    load_bit(6'd0, 6'd0, 1'b0);
    eval_at(32'h0000_4000, 32'h0000_c000);
    send(MODE_EVAL, 12'hfff, 1'b1, 32'h0003_0001, 32'h8000_7fff);
    drain();
    set_grid(7'd0, 7'd127);
    eval_at(32'h0005_8000, 32'h0042_4000);
    eval_at(32'hffff_ffff, 32'h0000_0001);
    drain();
    fill_table(1'b0, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 25 : (ph == 1) ? 76 : 0;
      recv_idle = (ph == 0) ? 76 : (ph == 1) ? 25 : 0;
      for (int s = 0; s < 2; s++) begin
        drain();
        set_grid(sizes[(2 * ph + s) % 6], sizes[(2 * ph + s + 3) % 6]);
        random_phase(200);
      end
    end
    drain();
    done = 1'b1;
    if (errors == 0) $display("gradient_noise_2d_unit verification clean");
    else $display("gradient_noise_2d_unit verification failed");
    $finish;
  end

endmodule
